// ===== rtl/core/vpv_pkg.sv =====
package vpv_pkg;

  localparam int unsigned SONG_VOICES = 21;

  localparam int unsigned TDATA_IN_W  = 96;
  localparam int unsigned TDATA_OUT_W = 56;

  localparam int unsigned VOL_W   = 9;   // 1..256 after decay offset
  localparam int unsigned LAW_W   = 14;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned PROD_W  = VOL_W + LAW_W;  // volume times law entry
  localparam int unsigned QUOT_W  = 16;  // product / 127
  localparam int unsigned EFX_W   = 18;  // second effect gain stage
  localparam int unsigned LEVEL_W = 25;

  // x / 127 == (x * DIV127_MUL) >> DIV127_SHIFT for every x below 2**PROD_W
  localparam int unsigned DIV127_SHIFT = 30;
  localparam int unsigned DIV127_MW    = 24;
  localparam logic [DIV127_MW-1:0] DIV127_MUL = 24'd8454661;

  localparam logic [6:0] PAN65_MAX    = 7'd64;
  localparam logic [6:0] PAN65_CENTER = 7'd32;
  localparam logic [5:0] PAN41_MAX    = 6'd40;
  localparam logic [5:0] PAN41_CENTER = 6'd20;
  localparam logic [1:0] PAN_MODE_FADER = 2'd2;

  typedef enum logic [1:0] {
    PATH_FADER,
    PATH_TRACK,
    PATH_EFFECT
  } vpv_path_t;

  // front-end result handed to the multiply pipeline
  typedef struct packed {
    vpv_path_t          path;
    logic               scale;   // apply master gain at the end
    logic [VOL_W-1:0]   vol;
    logic [LAW_W-1:0]   law_l;
    logic [LAW_W-1:0]   law_r;
    logic [GAIN_W-1:0]  gain;
  } vpv_front_t;

  localparam logic [LAW_W-1:0] LAW41 [0:40] = '{
    14'h0000, 14'h0141, 14'h0352, 14'h06F5, 14'h0A7A, 14'h0DE3, 14'h0F5D, 14'h12F7,
    14'h1617, 14'h1919, 14'h1A66, 14'h1D40, 14'h1FFC, 14'h229C, 14'h2404, 14'h2677,
    14'h28CE, 14'h2B07, 14'h2D24, 14'h2E44, 14'h2FFF, 14'h31A3, 14'h329D, 14'h344B,
    14'h35DB, 14'h374F, 14'h3811, 14'h3958, 14'h3A82, 14'h3B90, 14'h3C81, 14'h3CE3,
    14'h3DAA, 14'h3E55, 14'h3EF1, 14'h3F25, 14'h3F87, 14'h3FCB, 14'h3FF3, 14'h3FFF,
    14'h3FFF
  };

  localparam logic [LAW_W-1:0] LAW65 [0:64] = '{
    14'h0000, 14'h00C5, 14'h024D, 14'h04CF, 14'h0688, 14'h08F3, 14'h0A61, 14'h0CB7,
    14'h0E51, 14'h0FAC, 14'h11E3, 14'h1369, 14'h1589, 14'h16FF, 14'h18D5, 14'h1A3C,
    14'h1B9C, 14'h1D87, 14'h1EA8, 14'h207E, 14'h21BF, 14'h22CD, 14'h2485, 14'h25B0,
    14'h2751, 14'h2845, 14'h29D1, 14'h2ADD, 14'h2BE4, 14'h2D2C, 14'h2E23, 14'h2F7A,
    14'h2FFF, 14'h3082, 14'h31C0, 14'h3297, 14'h33A2, 14'h346A, 14'h352B, 14'h3634,
    14'h36CD, 14'h37C1, 14'h3863, 14'h3940, 14'h39BF, 14'h3A4C, 14'h3B0A, 14'h3B76,
    14'h3C1F, 14'h3C8E, 14'h3CF6, 14'h3D72, 14'h3DCB, 14'h3E3F, 14'h3E88, 14'h3EE5,
    14'h3F17, 14'h3F4A, 14'h3F89, 14'h3FA8, 14'h3FD2, 14'h3FE6, 14'h3FF9, 14'h3FFF,
    14'h3FFF
  };

endpackage

// ===== rtl/core/vpv_front.sv =====
module vpv_front (
  input  logic [4:0]            voice,
  input  logic [7:0]            note_volume,
  input  logic [7:0]            decay_offset,
  input  logic [1:0]            pan_mode,
  input  logic [16:0]           coarse_pan,
  input  logic [6:0]            fader_pan,
  input  logic [15:0]           master_gain,
  input  logic [7:0]            effect_class,
  input  logic [6:0]            effect_pan,
  input  logic [15:0]           effect_gain,
  input  logic                  mono_mode,
  output vpv_pkg::vpv_front_t   front
);
  import vpv_pkg::*;

  logic       song;
  logic [7:0] vol_base;
  logic [6:0] pan65_sel;
  logic [6:0] pan65;
  logic [8:0] step_raw;
  logic [5:0] pan41;

  assign song     = (voice < 5'(SONG_VOICES));
  assign vol_base = (note_volume >= decay_offset) ? (note_volume - decay_offset) : 8'd0;

  // fader pan for song voices, effect pan otherwise; saturate, then mono override
  assign pan65_sel = song ? fader_pan : effect_pan;
  always_comb begin
    pan65 = (pan65_sel > PAN65_MAX) ? PAN65_MAX : pan65_sel;
    if (mono_mode) begin
      pan65 = PAN65_CENTER;
    end
  end

  assign step_raw = coarse_pan[16:8];
  always_comb begin
    pan41 = (step_raw > 9'(PAN41_MAX)) ? PAN41_MAX : step_raw[5:0];
    if (mono_mode) begin
      pan41 = PAN41_CENTER;
    end
  end

  always_comb begin
    front.vol   = {1'b0, vol_base} + 9'd1;
    front.scale = song;
    if (song && (pan_mode == PAN_MODE_FADER)) begin
      front.path = PATH_FADER;
    end else if (song || (effect_class == 8'd0)) begin
      front.path = PATH_TRACK;
    end else begin
      front.path = PATH_EFFECT;
    end
    if (front.path == PATH_TRACK) begin
      front.law_l = LAW41[PAN41_MAX - pan41];
      front.law_r = LAW41[pan41];
    end else begin
      front.law_l = LAW65[PAN65_MAX - pan65];
      front.law_r = LAW65[pan65];
    end
    front.gain = (front.path == PATH_EFFECT) ? effect_gain : master_gain;
  end

endmodule

// ===== rtl/core/voice_pan_volume_calc_top.sv =====
// Stereo level pair for one voice-volume request.
//
// Input channel in_*: one transaction per request, accepted when in_tvalid and
// in_tready are both high. Result channel out_*: one transaction per request,
// in request order, carrying the left and right levels.
// cfg_wr_en / cfg_wr_data write the mono flag; write it only while idle.
//
// Throughput: one request per cycle while the receiver does not stall; four
// register stages (lookup, level product, divide by 127 through a reciprocal
// multiply, gain scaling), the last three holding one rank of multipliers each.
//
// Reset (rst_n low, synchronous) empties the pipeline and clears the mono flag.
// When the receiver stalls, the result holds on out_tdata and stages behind it
// keep filling any empty slots; in_tready drops only once every stage is full.
module voice_pan_volume_calc_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // voice, note_volume, decay_offset, pan_mode, coarse_pan, fader_pan,
  // master_gain, effect_class, effect_pan, effect_gain, zero pad
  input  logic [vpv_pkg::TDATA_IN_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // left_level, right_level, zero pad
  output logic [vpv_pkg::TDATA_OUT_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);
  import vpv_pkg::*;

  logic mono_mode_r;

  vpv_front_t front;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  vpv_front_t s1_r;

  // stage 2
  vpv_path_t          s2_path_r;
  logic               s2_scale_r;
  logic [LAW_W-1:0]   s2_law_l_r, s2_law_r_r;
  logic [GAIN_W-1:0]  s2_gain_r;
  logic [PROD_W-1:0]  s2_prod_l_r, s2_prod_r_r;
  logic [VOL_W-1:0]   s2_efx_r;
  logic [VOL_W+GAIN_W-1:0] efx1_full;

  // stage 3
  vpv_path_t          s3_path_r;
  logic               s3_scale_r;
  logic [LAW_W-1:0]   s3_law_l_r, s3_law_r_r;
  logic [GAIN_W-1:0]  s3_gain_r;
  logic [QUOT_W-1:0]  s3_quot_l_r, s3_quot_r_r;
  logic [EFX_W-1:0]   s3_efx_r;
  logic [PROD_W+DIV127_MW-1:0] div_l, div_r;
  logic [VOL_W+GAIN_W-1:0]     efx2_full;

  // stage 4
  logic [LEVEL_W-1:0] left_r, right_r;
  logic [LEVEL_W-1:0] left_nxt, right_nxt;
  logic [QUOT_W+GAIN_W-1:0] scl_l, scl_r;
  logic [EFX_W+LAW_W-1:0]   efx_l, efx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mono_mode_r <= cfg_wr_data;
    end
  end

  vpv_front u_front (
    .voice        (in_tdata[4:0]),
    .note_volume  (in_tdata[12:5]),
    .decay_offset (in_tdata[20:13]),
    .pan_mode     (in_tdata[22:21]),
    .coarse_pan   (in_tdata[39:23]),
    .fader_pan    (in_tdata[46:40]),
    .master_gain  (in_tdata[62:47]),
    .effect_class (in_tdata[70:63]),
    .effect_pan   (in_tdata[77:71]),
    .effect_gain  (in_tdata[93:78]),
    .mono_mode    (mono_mode_r),
    .front        (front)
  );

  // a stage advances when it is empty or the one after it advances
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_r <= front;
    end
  end

  assign efx1_full = (VOL_W+GAIN_W)'(s1_r.vol) * (VOL_W+GAIN_W)'(s1_r.gain);

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_path_r   <= s1_r.path;
      s2_scale_r  <= s1_r.scale;
      s2_law_l_r  <= s1_r.law_l;
      s2_law_r_r  <= s1_r.law_r;
      s2_gain_r   <= s1_r.gain;
      s2_prod_l_r <= PROD_W'(s1_r.vol) * PROD_W'(s1_r.law_l);
      s2_prod_r_r <= PROD_W'(s1_r.vol) * PROD_W'(s1_r.law_r);
      s2_efx_r    <= efx1_full[VOL_W+GAIN_W-1:GAIN_W];
    end
  end

  assign div_l     = (PROD_W+DIV127_MW)'(s2_prod_l_r) * (PROD_W+DIV127_MW)'(DIV127_MUL);
  assign div_r     = (PROD_W+DIV127_MW)'(s2_prod_r_r) * (PROD_W+DIV127_MW)'(DIV127_MUL);
  assign efx2_full = (VOL_W+GAIN_W)'(s2_efx_r) * (VOL_W+GAIN_W)'(s2_gain_r);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_path_r   <= s2_path_r;
      s3_scale_r  <= s2_scale_r;
      s3_law_l_r  <= s2_law_l_r;
      s3_law_r_r  <= s2_law_r_r;
      s3_gain_r   <= s2_gain_r;
      s3_quot_l_r <= div_l[DIV127_SHIFT+QUOT_W-1:DIV127_SHIFT];
      s3_quot_r_r <= div_r[DIV127_SHIFT+QUOT_W-1:DIV127_SHIFT];
      // second pass of the effect gain, then add one
      s3_efx_r    <= efx2_full[EFX_W+5:6] + EFX_W'(1);
    end
  end

  assign scl_l = (QUOT_W+GAIN_W)'(s3_quot_l_r) * (QUOT_W+GAIN_W)'(s3_gain_r);
  assign scl_r = (QUOT_W+GAIN_W)'(s3_quot_r_r) * (QUOT_W+GAIN_W)'(s3_gain_r);
  assign efx_l = (EFX_W+LAW_W)'(s3_efx_r) * (EFX_W+LAW_W)'(s3_law_l_r);
  assign efx_r = (EFX_W+LAW_W)'(s3_efx_r) * (EFX_W+LAW_W)'(s3_law_r_r);

  always_comb begin
    if (s3_path_r == PATH_EFFECT) begin
      left_nxt  = efx_l[EFX_W+LAW_W-1:7];
      right_nxt = efx_r[EFX_W+LAW_W-1:7];
    end else if (s3_scale_r) begin
      left_nxt  = LEVEL_W'(scl_l[QUOT_W+GAIN_W-1:GAIN_W]);
      right_nxt = LEVEL_W'(scl_r[QUOT_W+GAIN_W-1:GAIN_W]);
    end else begin
      left_nxt  = LEVEL_W'(s3_quot_l_r);
      right_nxt = LEVEL_W'(s3_quot_r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {(TDATA_OUT_W-2*LEVEL_W)'(0), right_r, left_r};

endmodule
